/* rtl/core/drpp_pkg.sv */
// ----------------------------------------------------------------------------
// drpp_pkg
// Shared types and codes of the deferred-release ping-pong log.
// ----------------------------------------------------------------------------
`default_nettype none

package drpp_pkg;

   localparam int SLOT_COUNT_DEF = 128;
   localparam int REF_W          = 32;
   localparam int PTR_W          = 8;
   localparam int IDX_W          = 7;
   localparam int KIND_W         = 3;
   localparam int RZ_W           = 7;
   localparam int CNT_W          = 32;

   localparam logic [RZ_W-1:0] RED_ZONE_RESET = 7'd32;

   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOST     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ENTRY    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NULL     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

   typedef struct packed {
      logic             action;
      logic [REF_W-1:0] obj_ref;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [REF_W-1:0]  ref_out;
      logic [IDX_W-1:0]  slot_index;
      logic [PTR_W-1:0]  fill_pointer;
      logic              trigger;
      logic [CNT_W-1:0]  lost_total;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic [PTR_W-1:0] put_ptr;
      logic [PTR_W-1:0] half_start;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/drpp_ram.sv */
// ----------------------------------------------------------------------------
// drpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drpp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/drpp_ctrl.sv */
// ----------------------------------------------------------------------------
// drpp_ctrl
// Put pointer, half switching, lost counter and the drain read sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module drpp_ctrl #(
   parameter int SLOT_COUNT = drpp_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [drpp_pkg::RZ_W-1:0]       red_zone,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire drpp_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output drpp_pkg::rsp_type                    rsp_data,
   output logic                                 wr_en,
   output logic [$clog2(SLOT_COUNT)-1:0]        wr_addr,
   output logic [drpp_pkg::REF_W-1:0]           wr_data,
   output logic                                 rd_en,
   output logic [$clog2(SLOT_COUNT)-1:0]        rd_addr,
   input  wire logic [drpp_pkg::REF_W-1:0]      rd_data,
   output drpp_pkg::status_type                 status
);

   localparam int AW   = $clog2(SLOT_COUNT);
   localparam int HALF = SLOT_COUNT / 2;
   localparam logic [drpp_pkg::PTR_W-1:0] HALF_P  = drpp_pkg::PTR_W'(HALF);
   localparam logic [drpp_pkg::PTR_W-1:0] UPPER_P = drpp_pkg::PTR_W'(HALF + 1);
   localparam logic [drpp_pkg::PTR_W-1:0] SLOT_P  = drpp_pkg::PTR_W'(SLOT_COUNT);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type                      state_ff, state_in;
   logic [drpp_pkg::PTR_W-1:0]     ptr_ff, ptr_in;
   logic [drpp_pkg::PTR_W-1:0]     hstart_ff, hstart_in;
   logic [drpp_pkg::CNT_W-1:0]     lost_ff, lost_in;
   logic [AW-1:0]                  pos_ff, pos_in;
   logic [drpp_pkg::PTR_W-1:0]     end_ff, end_in;
   logic                           data_ok_ff, data_ok_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   drpp_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                           out_free;
   logic                           take;
   logic                           trig;
   logic [drpp_pkg::PTR_W-1:0]     drn_start;
   logic [drpp_pkg::PTR_W-1:0]     drn_end;
   logic [drpp_pkg::PTR_W-1:0]     pos_ext;
   logic                           pos_last;
   logic [drpp_pkg::PTR_W:0]       rz_hi;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = !(state_ff == ST_IDLE && out_free);
      take      = req_valid && !req_stall;

      state_in     = state_ff;
      ptr_in       = ptr_ff;
      hstart_in    = hstart_ff;
      lost_in      = lost_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      data_ok_in   = data_ok_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      wr_en   = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = req_data.obj_ref;
      rd_en   = 1'b0;
      rd_addr = pos_ff;

      drn_start = (ptr_ff >= UPPER_P) ? UPPER_P : '0;
      drn_end   = (ptr_ff > SLOT_P) ? SLOT_P : ptr_ff;
      pos_ext   = drpp_pkg::PTR_W'(pos_ff);
      pos_last  = (pos_ext + 1'b1) == end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ref_out     = '0;
               rsp_data_in.slot_index  = '0;
               rsp_data_in.trigger     = 1'b0;
               rsp_data_in.last        = 1'b1;
               if (req_data.action == drpp_pkg::ACT_PUSH) begin
                  if (ptr_ff >= SLOT_P || ptr_ff == HALF_P) begin
                     // half full: drop the item and count it
                     if (lost_ff != '1) begin
                        lost_in = lost_ff + 1'b1;
                     end
                     rsp_data_in.kind = drpp_pkg::KIND_LOST;
                  end else begin
                     wr_en  = 1'b1;
                     ptr_in = ptr_ff + 1'b1;
                     rsp_data_in.kind       = drpp_pkg::KIND_ACCEPTED;
                     rsp_data_in.slot_index = drpp_pkg::IDX_W'(ptr_ff);
                  end
               end else if (ptr_ff == hstart_ff) begin
                  rsp_data_in.kind = drpp_pkg::KIND_EMPTY;
               end else begin
                  // switch halves, then walk the old one
                  ptr_in    = (ptr_ff > HALF_P) ? '0 : UPPER_P;
                  hstart_in = ptr_in;
                  if (drn_start >= drn_end) begin
                     rsp_data_in.kind = drpp_pkg::KIND_EMPTY;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_DRAIN;
                     pos_in       = drn_start[AW-1:0];
                     end_in       = drn_end;
                     data_ok_in   = 1'b0;
                  end
               end
               rsp_data_in.fill_pointer = ptr_in;
               rsp_data_in.lost_total   = lost_in;
            end
         end
         ST_DRAIN: begin
            if (!data_ok_ff) begin
               rd_en      = 1'b1;
               data_ok_in = 1'b1;
            end else if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.kind         = (rd_data == '0) ? drpp_pkg::KIND_NULL
                                                          : drpp_pkg::KIND_ENTRY;
               rsp_data_in.ref_out      = rd_data;
               rsp_data_in.slot_index   = drpp_pkg::IDX_W'(pos_ff);
               rsp_data_in.fill_pointer = ptr_ff;
               rsp_data_in.trigger      = 1'b0;
               rsp_data_in.lost_total   = lost_ff;
               rsp_data_in.last         = pos_last;
               if (pos_last) begin
                  state_in   = ST_IDLE;
                  data_ok_in = 1'b0;
               end else begin
                  // fetch the next slot while this one goes out
                  pos_in  = pos_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = pos_in;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // watermark test on the pointer after the push
      rz_hi = {2'b00, red_zone} + (drpp_pkg::PTR_W + 1)'(HALF);
      trig  = (ptr_in <= HALF_P && ptr_in > {1'b0, red_zone})
              || ({1'b0, ptr_in} > rz_hi);
      if (state_ff == ST_IDLE && take && req_data.action == drpp_pkg::ACT_PUSH) begin
         rsp_data_in.trigger = trig;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         hstart_ff    <= '0;
         lost_ff      <= '0;
         data_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         hstart_ff    <= hstart_in;
         lost_ff      <= lost_in;
         data_ok_ff   <= data_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign status    = '{busy: (state_ff == ST_DRAIN), put_ptr: ptr_ff, half_start: hstart_ff};

endmodule

`default_nettype wire

/* rtl/core/deferred_release_pingpong_log.sv */
// ----------------------------------------------------------------------------
// deferred_release_pingpong_log
// Ping-pong log of object references with deferred release by drains.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (push or drain); rsp_* carries result items; both
//   channels use valid/stall. csr_* writes the 7-bit red_zone watermark and
//   is always ready.
//   A push gives one result in the output register the cycle after it is
//   taken; pushes are taken one per cycle while the output drains.
//   A drain switches halves and streams the logged slots of the old half,
//   one per cycle while rsp_stall is low; each slot is read through the
//   registered read port of the slot memory into the output register. Up to
//   SLOT_COUNT/2 results follow; req_stall stays high until the last one is
//   loaded. An empty drain gives one result the cycle after it is taken.
//   Reset clears the pointers and the lost counter and sets red_zone to 32;
//   the slot memory is not cleared and needs no clearing pass, since only
//   slots written since the last switch are read.
//   While rsp_stall is high the output register holds its item and
//   req_stall rises, so no item is taken or lost.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_release_pingpong_log #(
   parameter int SLOT_COUNT = drpp_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire drpp_pkg::req_type         req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output drpp_pkg::rsp_type              rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [drpp_pkg::RZ_W-1:0] csr_data
);

   localparam int AW = $clog2(SLOT_COUNT);
   localparam logic [drpp_pkg::PTR_W-1:0] UPPER_P = drpp_pkg::PTR_W'(SLOT_COUNT / 2 + 1);
   localparam logic [drpp_pkg::PTR_W-1:0] SLOT_P  = drpp_pkg::PTR_W'(SLOT_COUNT);

   logic [drpp_pkg::RZ_W-1:0]  red_zone_ff, red_zone_in;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [drpp_pkg::REF_W-1:0] wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [drpp_pkg::REF_W-1:0] rd_data;
   drpp_pkg::status_type       status;

   assign csr_ready   = 1'b1;
   assign red_zone_in = (csr_valid && csr_ready) ? csr_data : red_zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_zone_ff <= drpp_pkg::RED_ZONE_RESET;
      end else begin
         red_zone_ff <= red_zone_in;
      end
   end

   drpp_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .red_zone  (red_zone_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .status    (status)
   );

   drpp_ram #(
      .WIDTH (drpp_pkg::REF_W),
      .DEPTH (SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_ptr_range : assert property (@(posedge clock) disable iff (reset)
      status.put_ptr <= SLOT_P)
      else $error("put pointer beyond the store");

   a_half_start : assert property (@(posedge clock) disable iff (reset)
      status.half_start == '0 || status.half_start == UPPER_P)
      else $error("half start not at a half boundary");

   a_busy_stall : assert property (@(posedge clock) disable iff (reset)
      status.busy |-> req_stall)
      else $error("item taken during a drain");

   a_push_result : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.action == drpp_pkg::ACT_PUSH)
      |=> (rsp_valid && rsp_data.last
           && (rsp_data.kind == drpp_pkg::KIND_ACCEPTED
               || rsp_data.kind == drpp_pkg::KIND_LOST)))
      else $error("push without its single result");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression for the deferred-release ping-pong log. Pushes and drains are
// sent with random gaps while the result side stalls at random. Each
// accepted item runs through a local model of the two-half slot log. Every
// result item is compared with the oldest result that the model produced.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = drpp_pkg::SLOT_COUNT_DEF;
   localparam int HALF       = SLOTS / 2;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 33;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   drpp_pkg::req_type          req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   drpp_pkg::rsp_type          rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [drpp_pkg::RZ_W-1:0]  csr_data  = '0;

   // model of the log
   logic [drpp_pkg::REF_W-1:0] log_slot [SLOTS];
   int unsigned                log_put;
   int unsigned                log_half_start;
   logic [drpp_pkg::CNT_W-1:0] log_lost;
   int unsigned                log_red_zone;

   drpp_pkg::rsp_type          rsp_due [$];
   int                         fail_cnt = 0;
   int                         idle_cycles = 0;

   deferred_release_pingpong_log dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit trigger_now();
      int unsigned p;
      p = log_put;
      return (p <= HALF && p > log_red_zone) || (p > log_red_zone + HALF);
   endfunction

   function automatic drpp_pkg::rsp_type make_rsp(logic [drpp_pkg::KIND_W-1:0] kind,
                                                  logic [drpp_pkg::REF_W-1:0] ref_v,
                                                  int unsigned idx, bit trig,
                                                  bit is_last);
      drpp_pkg::rsp_type r;
      r.kind         = kind;
      r.ref_out      = ref_v;
      r.slot_index   = idx[drpp_pkg::IDX_W-1:0];
      r.fill_pointer = log_put[drpp_pkg::PTR_W-1:0];
      r.trigger      = trig;
      r.lost_total   = log_lost;
      r.last         = is_last;
      return r;
   endfunction

   task automatic apply_log_item(input drpp_pkg::req_type it);
      int unsigned pos;
      int unsigned old_put;
      int unsigned start;
      int unsigned new_ptr;
      int          n;
      logic [drpp_pkg::REF_W-1:0] v;
      if (it.action == drpp_pkg::ACT_PUSH) begin
         if (log_put >= SLOTS || log_put == HALF) begin
            if (log_lost != '1) log_lost++;
            rsp_due.push_back(make_rsp(drpp_pkg::KIND_LOST, '0, 0, trigger_now(), 1'b1));
         end else begin
            pos = log_put;
            log_slot[pos] = it.obj_ref;
            log_put = pos + 1;
            rsp_due.push_back(make_rsp(drpp_pkg::KIND_ACCEPTED, '0, pos, trigger_now(),
                                       1'b1));
         end
      end else if (log_put == log_half_start) begin
         rsp_due.push_back(make_rsp(drpp_pkg::KIND_EMPTY, '0, 0, 1'b0, 1'b1));
      end else begin
         old_put = log_put;
         new_ptr = (old_put > HALF) ? 0 : HALF + 1;
         start = (old_put >= HALF + 1) ? HALF + 1 : 0;
         log_put = new_ptr;
         log_half_start = new_ptr;
         if (old_put > SLOTS) old_put = SLOTS;
         n = 0;
         for (pos = start; pos < old_put; pos++) begin
            v = log_slot[pos];
            rsp_due.push_back(make_rsp((v == 0) ? drpp_pkg::KIND_NULL : drpp_pkg::KIND_ENTRY,
                                       v, pos, 1'b0, pos + 1 == old_put));
            n++;
         end
         if (n == 0) rsp_due.push_back(make_rsp(drpp_pkg::KIND_EMPTY, '0, 0, 1'b0, 1'b1));
      end
   endtask

   task automatic note_fail(input string what, input drpp_pkg::rsp_type e,
                            input drpp_pkg::rsp_type a);
      fail_cnt++;
      if (fail_cnt <= 10) begin
         $display("%s: exp kind=%0d ref=%h idx=%0d fp=%0d trig=%0d lost=%0d last=%0d",
                  what, e.kind, e.ref_out, e.slot_index, e.fill_pointer, e.trigger,
                  e.lost_total, e.last);
         $display("   act kind=%0d ref=%h idx=%0d fp=%0d trig=%0d lost=%0d last=%0d",
                  a.kind, a.ref_out, a.slot_index, a.fill_pointer, a.trigger,
                  a.lost_total, a.last);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      drpp_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            note_fail("unexpected result", '0, rsp_data);
         end else begin
            e = rsp_due.pop_front();
            if (rsp_data.kind !== e.kind || rsp_data.ref_out !== e.ref_out ||
                rsp_data.slot_index !== e.slot_index ||
                rsp_data.fill_pointer !== e.fill_pointer ||
                rsp_data.trigger !== e.trigger || rsp_data.lost_total !== e.lost_total ||
                rsp_data.last !== e.last) begin
               note_fail("result mismatch", e, rsp_data);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", rsp_due.size());
         $display("deferred_release_pingpong_log regression: fail");
         $finish;
      end
   end

   // result-side stall: short and long stalls, with runs of no stall between
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_stall <= 1'b0;
            run_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 3);
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 8);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [drpp_pkg::REF_W-1:0] pick_ref();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // Leaves req_valid high after acceptance; the next call replaces the item or lowers it, or a hold-off lowers it.
   task automatic send_item(input logic action, input logic [drpp_pkg::REF_W-1:0] ref_v);
      drpp_pkg::req_type it;
      int                gap;
      it.action  = action;
      it.obj_ref = ref_v;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      apply_log_item(it);
   endtask

   // hold the sender until every predicted result has come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_red_zone(input int unsigned value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[drpp_pkg::RZ_W-1:0];
      do @(posedge clock); while (!csr_ready);
      log_red_zone = value & 32'h7F;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_run(input int count);
      repeat (count) send_item(drpp_pkg::ACT_PUSH, pick_ref());
   endtask

   // empty drains, both half switches, null and extreme references
   task automatic test_drain_basics();
      send_item(drpp_pkg::ACT_DRAIN, '0);
      send_item(drpp_pkg::ACT_PUSH, '0);
      send_item(drpp_pkg::ACT_PUSH, '1);
      send_item(drpp_pkg::ACT_PUSH, 32'h8000_0001);
      send_item(drpp_pkg::ACT_PUSH, 32'h7FFF_FFFE);
      send_item(drpp_pkg::ACT_DRAIN, '1);
      send_item(drpp_pkg::ACT_DRAIN, '0);
      send_item(drpp_pkg::ACT_PUSH, 32'h0000_0001);
      send_item(drpp_pkg::ACT_PUSH, '0);
      send_item(drpp_pkg::ACT_DRAIN, 32'h5555_AAAA);
      send_item(drpp_pkg::ACT_DRAIN, '0);
   endtask

   // fill the lower half past its end: drop, lost count, full-length drain
   task automatic test_full_half();
      write_red_zone(0);
      push_run(HALF + 1);
      send_item(drpp_pkg::ACT_DRAIN, '0);
   endtask

   task automatic test_random_traffic();
      int sent;
      int n;
      int r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 11);
         if (r == 0) write_red_zone($urandom_range(0, 64));
         else if (r == 1) write_red_zone(($urandom_range(0, 1) == 0) ? 0 : 64);
         else if (r == 2) wait_drained();
         n = $urandom_range(0, 10);
         push_run(n);
         send_item(drpp_pkg::ACT_DRAIN, pick_ref());
         sent += n + 1;
         // noise: stray drains and stray pushes
         if ($urandom_range(0, 7) == 0) begin
            send_item(drpp_pkg::ACT_DRAIN, pick_ref());
            sent++;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(drpp_pkg::ACT_PUSH, pick_ref());
            sent++;
         end
      end
   endtask

   initial begin
      log_put        = 0;
      log_half_start = 0;
      log_lost       = '0;
      log_red_zone   = drpp_pkg::RED_ZONE_RESET;
      foreach (log_slot[i]) log_slot[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_drain_basics();
      test_full_half();
      test_random_traffic();

      wait_drained();
      repeat (20) @(negedge clock);
      while (rsp_due.size() != 0) begin
         note_fail("missing result", rsp_due.pop_front(), '0);
      end
      if (fail_cnt == 0) begin
         $display("deferred_release_pingpong_log regression: pass");
      end else begin
         $display("deferred_release_pingpong_log regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
